FILE: rtl/urbi_pkg.sv
// Shared types and constants for the ultrasonic range band indicator.
// Used by urbi_dist, urbi_core and the top level; depends on nothing.
`default_nettype none

package urbi_pkg;

   // sensor timing and scaling
   localparam int unsigned TRIG_LOW_TICKS  = 2;
   localparam int unsigned TRIG_HIGH_TICKS = 10;
   localparam int unsigned TICKS_PER_MM    = 6;
   localparam int unsigned MAX_DISTANCE    = 5000;

   // reciprocal of TICKS_PER_MM for a 16-bit dividend, exact after the shift
   localparam int unsigned RECIP_SHIFT = 18;
   localparam int unsigned RECIP_MULT  = ((1 << RECIP_SHIFT) + TICKS_PER_MM - 1) / TICKS_PER_MM;

   // field widths
   localparam int unsigned DIST_W     = 13;
   localparam int unsigned TIMEOUT_W  = 16;
   localparam int unsigned DEBOUNCE_W = 18;
   localparam int unsigned GAP_W      = 17;
   localparam int unsigned FAULT_W    = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 18;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 24;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_TIMEOUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_GAP    = 3'd6;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_NO_RISE   = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_ECHO_LONG = 2'd2;

   // ranging cycle phases
   typedef enum logic [4:0] {
      PH_GAP       = 5'b00001,
      PH_TRIG_LOW  = 5'b00010,
      PH_TRIG_HIGH = 5'b00100,
      PH_WAIT_RISE = 5'b01000,
      PH_MEASURE   = 5'b10000
   } phase_type;

   // configuration registers
   typedef struct packed {
      logic [DIST_W-1:0]     near_limit_mm;
      logic [DIST_W-1:0]     band_low_mm;
      logic [DIST_W-1:0]     band_high_mm;
      logic [TIMEOUT_W-1:0]  rise_timeout_us;
      logic [TIMEOUT_W-1:0]  echo_timeout_us;
      logic [DEBOUNCE_W-1:0] debounce_us;
      logic [GAP_W-1:0]      repeat_gap_us;
   } cfg_type;

   // LED pair chosen for a distance
   typedef struct packed {
      logic red;
      logic green;
   } led_type;

   // one result item
   typedef struct packed {
      logic [FAULT_W-1:0] fault_code;
      logic [DIST_W-1:0]  distance_mm;
      logic               distance_valid;
      logic               ranging_enabled;
      logic               led_green;
      logic               led_red;
      logic               trigger_level;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/ultrasonic_range_band_indicator.sv
// Ultrasonic range band indicator. Each req item is one microsecond tick of the
// sampled echo pin and button; each tick yields exactly one rsp item with the
// trigger level, LED drive, enable flag, distance and fault. One item is taken
// per clock cycle unless the rsp side stalls; an item's result passes through
// the input register and then the result register around the single-pass
// sequencer. A stalled rsp side holds the pipeline; req_tready drops only when
// both registers are full. The user is to write registers on the csr port only
// while idle; the block does not enforce it. Depends on urbi_pkg and urbi_core.
`default_nettype none

module ultrasonic_range_band_indicator
   import urbi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: [0] echo_level, [1] button_edge, rest zero
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: [0] trigger_level, [1] led_red, [2] led_green,
   // [3] ranging_enabled, [4] distance_valid, [17:5] distance_mm,
   // [19:18] fault_code, rest zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type       cfg_ff;
   logic          in_valid_ff;
   logic          in_echo_ff;
   logic          in_edge_ff;
   logic          out_valid_ff;
   rsp_type       out_ff;
   rsp_type       core_rsp;
   logic          advance;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit_mm   <= DIST_W'(150);
         cfg_ff.band_low_mm     <= DIST_W'(200);
         cfg_ff.band_high_mm    <= DIST_W'(600);
         cfg_ff.rise_timeout_us <= TIMEOUT_W'(40000);
         cfg_ff.echo_timeout_us <= TIMEOUT_W'(30000);
         cfg_ff.debounce_us     <= DEBOUNCE_W'(200000);
         cfg_ff.repeat_gap_us   <= GAP_W'(100000);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NEAR_LIMIT:   cfg_ff.near_limit_mm   <= csr_data[DIST_W-1:0];
            CSR_BAND_LOW:     cfg_ff.band_low_mm     <= csr_data[DIST_W-1:0];
            CSR_BAND_HIGH:    cfg_ff.band_high_mm    <= csr_data[DIST_W-1:0];
            CSR_RISE_TIMEOUT: cfg_ff.rise_timeout_us <= csr_data[TIMEOUT_W-1:0];
            CSR_ECHO_TIMEOUT: cfg_ff.echo_timeout_us <= csr_data[TIMEOUT_W-1:0];
            CSR_DEBOUNCE:     cfg_ff.debounce_us     <= csr_data[DEBOUNCE_W-1:0];
            CSR_REPEAT_GAP:   cfg_ff.repeat_gap_us   <= csr_data[GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_echo_ff <= req_tdata[0];
         in_edge_ff <= req_tdata[1];
      end
   end

   urbi_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .echo_level  (in_echo_ff),
      .button_edge (in_edge_ff),
      .cfg         (cfg_ff),
      .rsp         (core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-$bits(rsp_type))'(0), out_ff};

endmodule

`default_nettype wire

FILE: rtl/urbi_dist.sv
// Echo pulse length to millimetres, saturation and LED band selection.
// Depends on urbi_pkg.
`default_nettype none

module urbi_dist
   import urbi_pkg::*;
(
   input  wire logic [TIMEOUT_W-1:0] pulse_ticks,
   input  wire cfg_type              cfg,
   output logic [DIST_W-1:0]         dist_mm,
   output logic                      dist_nonzero,
   output led_type                   leds
);

   localparam int unsigned PROD_W = TIMEOUT_W + RECIP_SHIFT;

   logic [PROD_W-1:0]    prod;
   logic [TIMEOUT_W-1:0] quot;

   // divide by ticks per mm through the reciprocal
   assign prod = {{RECIP_SHIFT{1'b0}}, pulse_ticks} * PROD_W'(RECIP_MULT);
   assign quot = prod[PROD_W-1:RECIP_SHIFT];

   // clamp to the sensor range
   always_comb begin
      if (quot > TIMEOUT_W'(MAX_DISTANCE)) begin
         dist_mm = DIST_W'(MAX_DISTANCE);
      end else begin
         dist_mm = quot[DIST_W-1:0];
      end
   end

   assign dist_nonzero = (dist_mm != '0);

   // red when near, both inside the band, green otherwise
   always_comb begin
      priority if (dist_mm < cfg.near_limit_mm) begin
         leds.red   = 1'b1;
         leds.green = 1'b0;
      end else if (dist_mm > cfg.band_low_mm && dist_mm < cfg.band_high_mm) begin
         leds.red   = 1'b1;
         leds.green = 1'b1;
      end else begin
         leds.red   = 1'b0;
         leds.green = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/urbi_core.sv
// Ranging sequencer, button toggle with debounce and LED state, one tick per step.
// Depends on urbi_pkg and urbi_dist.
`default_nettype none

module urbi_core
   import urbi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire logic    echo_level,
   input  wire logic    button_edge,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   phase_type             phase_ff, phase_in;
   logic [GAP_W-1:0]      ticks_ff, ticks_in;
   logic [TIMEOUT_W-1:0]  pulse_ff, pulse_in;
   logic                  enabled_ff, enabled_in;
   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic                  red_ff, red_in;
   logic                  green_ff, green_in;
   logic [DIST_W-1:0]     last_dist_ff, last_dist_in;

   logic [GAP_W:0]        tick_inc;
   logic [TIMEOUT_W:0]    high_count;
   logic [FAULT_W-1:0]    fault;
   logic                  valid;
   logic [DIST_W-1:0]     dist_mm;
   logic                  dist_nonzero;
   led_type               dist_leds;

   urbi_dist u_dist (
      .pulse_ticks  (pulse_ff),
      .cfg          (cfg),
      .dist_mm      (dist_mm),
      .dist_nonzero (dist_nonzero),
      .leds         (dist_leds)
   );

   assign tick_inc = {1'b0, ticks_ff} + 1'b1;

   // an echo-high tick counts from one on the rising tick
   always_comb begin
      if (phase_ff == PH_WAIT_RISE) begin
         high_count = (TIMEOUT_W+1)'(1);
      end else begin
         high_count = {1'b0, pulse_ff} + 1'b1;
      end
   end

   // phase sequencing and measurement
   always_comb begin
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      pulse_in     = pulse_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      last_dist_in = last_dist_ff;
      fault        = FAULT_NONE;
      valid        = 1'b0;
      unique case (phase_ff)
         PH_TRIG_LOW: begin
            ticks_in = tick_inc[GAP_W-1:0];
            if (tick_inc >= (GAP_W+1)'(TRIG_LOW_TICKS)) begin
               phase_in = PH_TRIG_HIGH;
               ticks_in = '0;
            end
         end
         PH_TRIG_HIGH: begin
            ticks_in = tick_inc[GAP_W-1:0];
            if (tick_inc >= (GAP_W+1)'(TRIG_HIGH_TICKS)) begin
               phase_in = PH_WAIT_RISE;
               ticks_in = '0;
               pulse_in = '0;
            end
         end
         PH_WAIT_RISE, PH_MEASURE: begin
            if (echo_level) begin
               if (high_count > {1'b0, cfg.echo_timeout_us}) begin
                  phase_in = PH_GAP;
                  ticks_in = '0;
                  pulse_in = '0;
                  fault    = FAULT_ECHO_LONG;
               end else begin
                  phase_in = PH_MEASURE;
                  pulse_in = high_count[TIMEOUT_W-1:0];
               end
            end else if (phase_ff == PH_WAIT_RISE) begin
               ticks_in = tick_inc[GAP_W-1:0];
               if (tick_inc > {2'b00, cfg.rise_timeout_us}) begin
                  phase_in = PH_GAP;
                  ticks_in = '0;
                  pulse_in = '0;
                  fault    = FAULT_NO_RISE;
               end
            end else begin
               // echo fell: pulse complete
               if (dist_nonzero) begin
                  last_dist_in = dist_mm;
                  valid        = 1'b1;
                  red_in       = dist_leds.red;
                  green_in     = dist_leds.green;
               end
               phase_in = PH_GAP;
               ticks_in = '0;
               pulse_in = '0;
            end
         end
         default: begin
            // gap, and any code that cannot arise
            phase_in = PH_GAP;
            ticks_in = tick_inc[GAP_W-1:0];
            if (tick_inc >= {1'b0, cfg.repeat_gap_us}) begin
               ticks_in = '0;
               if (enabled_ff) begin
                  phase_in = PH_TRIG_LOW;
               end
            end
         end
      endcase
   end

   // button toggle overrides the leds set by a measurement on the same tick
   always_comb begin
      enabled_in  = enabled_ff;
      debounce_in = debounce_ff;
      if (button_edge && debounce_ff == '0) begin
         enabled_in  = !enabled_ff;
         debounce_in = cfg.debounce_us;
      end else if (debounce_ff != '0) begin
         debounce_in = debounce_ff - 1'b1;
      end
   end

   // result of this tick
   always_comb begin
      rsp.trigger_level   = (phase_ff == PH_TRIG_HIGH);
      rsp.ranging_enabled = enabled_in;
      rsp.distance_valid  = valid;
      rsp.distance_mm     = last_dist_in;
      rsp.fault_code      = fault;
      if (button_edge && debounce_ff == '0) begin
         rsp.led_red   = 1'b0;
         rsp.led_green = enabled_in;
      end else begin
         rsp.led_red   = red_in;
         rsp.led_green = green_in;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GAP;
         ticks_ff     <= '0;
         pulse_ff     <= '0;
         enabled_ff   <= 1'b0;
         debounce_ff  <= '0;
         red_ff       <= 1'b0;
         green_ff     <= 1'b0;
         last_dist_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         pulse_ff     <= pulse_in;
         enabled_ff   <= enabled_in;
         debounce_ff  <= debounce_in;
         red_ff       <= rsp.led_red;
         green_ff     <= rsp.led_green;
         last_dist_ff <= last_dist_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_range_band_indicator: drives echo/button ticks,
// predicts every result item in a scoreboard class and compares field by field.
// Depends on urbi_pkg and the block's RTL.

module tb;
   import urbi_pkg::*;

   // ranging state mirror and expected result store
   class ranger_scoreboard;
      logic [DIST_W-1:0]     near_mm, band_lo_mm, band_hi_mm;
      logic [TIMEOUT_W-1:0]  rise_to, echo_to;
      logic [DEBOUNCE_W-1:0] debounce_len;
      logic [GAP_W-1:0]      gap_len;

      phase_type             phase;
      logic [GAP_W-1:0]      phase_ticks;
      logic [TIMEOUT_W-1:0]  pulse_ticks;
      logic [DEBOUNCE_W-1:0] debounce_left;
      logic [DIST_W-1:0]     last_mm;
      bit                    enabled, red_on, green_on;

      rsp_type               pending_results[$];
      int unsigned           mismatches;
      int unsigned           result_count;

      function new();
         near_mm       = DIST_W'(150);
         band_lo_mm    = DIST_W'(200);
         band_hi_mm    = DIST_W'(600);
         rise_to       = TIMEOUT_W'(40000);
         echo_to       = TIMEOUT_W'(30000);
         debounce_len  = DEBOUNCE_W'(200000);
         gap_len       = GAP_W'(100000);
         enabled       = 0;
         red_on        = 0;
         green_on      = 0;
         debounce_left = '0;
         last_mm       = '0;
         mismatches    = 0;
         result_count  = 0;
         go_idle();
      endfunction

      function void go_idle();
         phase       = PH_GAP;
         phase_ticks = '0;
         pulse_ticks = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NEAR_LIMIT:   near_mm      = data[DIST_W-1:0];
            CSR_BAND_LOW:     band_lo_mm   = data[DIST_W-1:0];
            CSR_BAND_HIGH:    band_hi_mm   = data[DIST_W-1:0];
            CSR_RISE_TIMEOUT: rise_to      = data[TIMEOUT_W-1:0];
            CSR_ECHO_TIMEOUT: echo_to      = data[TIMEOUT_W-1:0];
            CSR_DEBOUNCE:     debounce_len = data[DEBOUNCE_W-1:0];
            CSR_REPEAT_GAP:   gap_len      = data[GAP_W-1:0];
            default: ;
         endcase
      endfunction

      // one echo-high tick of the pulse
      function logic [FAULT_W-1:0] count_high();
         int unsigned n;
         n = pulse_ticks + 1;
         if (n > echo_to) begin
            go_idle();
            return FAULT_ECHO_LONG;
         end
         pulse_ticks = n[TIMEOUT_W-1:0];
         phase = PH_MEASURE;
         return FAULT_NONE;
      endfunction

      // advance one tick and queue the result it must produce
      function void note_tick(bit echo, bit btn);
         rsp_type     r;
         int unsigned t;
         int unsigned d;
         r = '0;
         r.trigger_level = (phase == PH_TRIG_HIGH);
         case (phase)
            PH_TRIG_LOW: begin
               phase_ticks++;
               if (phase_ticks >= TRIG_LOW_TICKS) begin
                  phase = PH_TRIG_HIGH;
                  phase_ticks = '0;
               end
            end
            PH_TRIG_HIGH: begin
               phase_ticks++;
               if (phase_ticks >= TRIG_HIGH_TICKS) begin
                  phase = PH_WAIT_RISE;
                  phase_ticks = '0;
                  pulse_ticks = '0;
               end
            end
            PH_WAIT_RISE: begin
               if (echo) begin
                  pulse_ticks = '0;
                  r.fault_code = count_high();
               end else begin
                  t = phase_ticks + 1;
                  phase_ticks = t[GAP_W-1:0];
                  if (t > rise_to) begin
                     go_idle();
                     r.fault_code = FAULT_NO_RISE;
                  end
               end
            end
            PH_MEASURE: begin
               if (echo) begin
                  r.fault_code = count_high();
               end else begin
                  d = pulse_ticks / TICKS_PER_MM;
                  if (d > MAX_DISTANCE) d = MAX_DISTANCE;
                  if (d != 0) begin
                     last_mm = d[DIST_W-1:0];
                     r.distance_valid = 1'b1;
                     if (d < near_mm) begin
                        red_on = 1;
                        green_on = 0;
                     end else if (d > band_lo_mm && d < band_hi_mm) begin
                        red_on = 1;
                        green_on = 1;
                     end else begin
                        red_on = 0;
                        green_on = 1;
                     end
                  end
                  go_idle();
               end
            end
            default: begin
               phase = PH_GAP;
               t = phase_ticks + 1;
               phase_ticks = t[GAP_W-1:0];
               if (t >= gap_len) begin
                  phase_ticks = '0;
                  if (enabled) phase = PH_TRIG_LOW;
               end
            end
         endcase

         // button toggle comes after the measurement, so it wins
         if (btn && debounce_left == 0) begin
            enabled = !enabled;
            red_on = 0;
            green_on = enabled;
            debounce_left = debounce_len;
         end else if (debounce_left != 0) begin
            debounce_left--;
         end

         r.led_red         = red_on;
         r.led_green       = green_on;
         r.ranging_enabled = enabled;
         r.distance_mm     = last_mm;
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data);
         rsp_type got, want;
         got = rsp_type'(data[$bits(rsp_type)-1:0]);
         result_count++;
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("result %0d arrived with nothing expected: %h", result_count, data);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.trigger_level !== want.trigger_level || got.led_red !== want.led_red ||
             got.led_green !== want.led_green || got.ranging_enabled !== want.ranging_enabled ||
             got.distance_valid !== want.distance_valid ||
             got.distance_mm !== want.distance_mm || got.fault_code !== want.fault_code) begin
            if (mismatches < 10) begin
               $display("result %0d mismatch: exp trig=%0b red=%0b green=%0b en=%0b vld=%0b mm=%0d flt=%0d",
                        result_count, want.trigger_level, want.led_red, want.led_green,
                        want.ranging_enabled, want.distance_valid, want.distance_mm,
                        want.fault_code);
               $display("   got trig=%0b red=%0b green=%0b en=%0b vld=%0b mm=%0d flt=%0d",
                        got.trigger_level, got.led_red, got.led_green, got.ranging_enabled,
                        got.distance_valid, got.distance_mm, got.fault_code);
            end
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction
   endclass

   typedef enum int {PRESS_NONE, PRESS_DURING_ECHO, PRESS_ON_FALL} press_mode_type;

   localparam int unsigned STALL_LIMIT = 5000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   ranger_scoreboard sb = new();

   // echo sensor emulation
   bit             calm;
   bit             armed;
   bit             noisy;
   int unsigned    low_left, high_left;
   int unsigned    press_rate;
   press_mode_type press;
   int unsigned    forced_low[$], forced_high[$];
   press_mode_type forced_press[$];
   int unsigned    stall_cycles;

   ultrasonic_range_band_indicator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // result side backpressure
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 26);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // pick the echo shape for the next ranging cycle
   task automatic plan_echo();
      int unsigned r, cap;
      if (forced_low.size() != 0) begin
         low_left  = forced_low.pop_front();
         high_left = forced_high.pop_front();
         press     = forced_press.pop_front();
         noisy     = 0;
         return;
      end
      noisy = ($urandom_range(0, 19) == 0);
      press = PRESS_NONE;
      if ($urandom_range(0, 29) == 0) press = press_mode_type'($urandom_range(1, 2));
      r = $urandom_range(0, 9);
      if (r < 7) low_left = $urandom_range(0, 8);
      else if (r < 9 && sb.rise_to <= 300) low_left = $urandom_range(sb.rise_to - 1, sb.rise_to + 1);
      else low_left = $urandom_range(0, 40);
      cap = 6 * (sb.band_hi_mm + 5);
      if (cap > 300) cap = 300;
      r = $urandom_range(0, 9);
      if (r < 6) high_left = $urandom_range(6, cap);
      else if (r < 7) high_left = $urandom_range(0, 7);
      else if (r < 9 && sb.echo_to <= 300)
         high_left = $urandom_range(sb.echo_to - 1, sb.echo_to + 2);
      else high_left = $urandom_range(0, 300);
   endtask

   // next tick from the current predicted phase
   task automatic make_tick(output bit echo, output bit btn);
      bit in_cycle;
      in_cycle = (sb.phase == PH_WAIT_RISE) || (sb.phase == PH_MEASURE);
      if (in_cycle) begin
         if (!armed) plan_echo();
         armed = 1;
         if (noisy) begin
            echo = 1'($urandom_range(0, 1));
         end else if (low_left != 0) begin
            echo = 0;
            low_left--;
         end else if (high_left != 0) begin
            echo = 1;
            high_left--;
         end else begin
            echo = 0;
         end
      end else begin
         armed = 0;
         echo = ($urandom_range(0, 9) == 0);
      end
      btn = 0;
      if (sb.phase == PH_MEASURE && press == PRESS_DURING_ECHO && echo) begin
         btn = 1;
         press = PRESS_NONE;
      end else if (sb.phase == PH_MEASURE && press == PRESS_ON_FALL && !echo) begin
         btn = 1;
         press = PRESS_NONE;
      end else if (!sb.enabled) begin
         btn = ($urandom_range(0, 9) == 0);
      end else begin
         btn = ($urandom_range(0, 999) < press_rate);
      end
   endtask

   task automatic send_tick(input bit echo, input bit btn);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({btn, echo});
      do @(posedge clock); while (!req_tready);
      sb.note_tick(echo, btn);
   endtask

   task automatic run_ticks(input int unsigned n);
      bit e, b;
      repeat (n) begin
         make_tick(e, b);
         send_tick(e, b);
      end
   endtask

   // hold the sender until every expected item is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input int unsigned near, lo, hi, rise, echo_to, deb, gap);
      logic [CSR_IDX_W-1:0]  idx_list [7];
      logic [CSR_DATA_W-1:0] vals [7];
      idx_list = '{CSR_NEAR_LIMIT, CSR_BAND_LOW, CSR_BAND_HIGH, CSR_RISE_TIMEOUT,
                   CSR_ECHO_TIMEOUT, CSR_DEBOUNCE, CSR_REPEAT_GAP};
      vals = '{CSR_DATA_W'(near), CSR_DATA_W'(lo), CSR_DATA_W'(hi), CSR_DATA_W'(rise),
               CSR_DATA_W'(echo_to), CSR_DATA_W'(deb), CSR_DATA_W'(gap)};
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx_list[i], vals[i]);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_plan(input int unsigned low, high, input press_mode_type mode);
      forced_low.push_back(low);
      forced_high.push_back(high);
      forced_press.push_back(mode);
   endtask

   task automatic random_phase(input int unsigned n);
      int unsigned lo;
      lo = $urandom_range(0, 20);
      drain();
      set_config($urandom_range(0, 20), lo, $urandom_range(lo, 35), $urandom_range(1, 60),
                 $urandom_range(12, 250), $urandom_range(0, 120), $urandom_range(0, 40));
      run_ticks(n);
   endtask

   initial begin
      bit e, b;
      calm = 0;
      armed = 0;
      noisy = 0;
      press = PRESS_NONE;
      press_rate = 0;
      low_left = 0;
      high_left = 0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a few ticks under the reset register values
      send_tick(0, 0);
      send_tick(1, 0);
      send_tick(0, 0);

      // directed cycles: no rise, short pulse, red, yellow, green,
      // disable mid cycle, toggle on the completing tick
      drain();
      set_config(10, 20, 4000, 3, 65535, 0, 0);
      add_plan(4, 0, PRESS_NONE);
      add_plan(0, 5, PRESS_NONE);
      add_plan(0, 32, PRESS_NONE);
      add_plan(2, 130, PRESS_NONE);
      add_plan(1, 90, PRESS_NONE);
      add_plan(3, 180, PRESS_DURING_ECHO);
      add_plan(0, 72, PRESS_ON_FALL);
      do begin
         make_tick(e, b);
         send_tick(e, b);
      end while (forced_low.size() != 0 || armed);

      // echo too long at the smallest timeouts, no gap, no debounce
      drain();
      set_config(0, 0, 0, 1, 1, 0, 0);
      add_plan(0, 3, PRESS_NONE);
      press_rate = 5;
      run_ticks(150);

      drain();
      set_config(5, 8, 15, 30, 150, 20, 10);
      run_ticks(150);

      // sender hold-off in the middle of a phase
      random_phase(125);
      drain();
      run_ticks(125);

      calm = 1;
      random_phase(150);
      calm = 0;

      random_phase(150);

      // largest bounds, timeouts and debounce
      drain();
      press_rate = 0;
      set_config(5000, 0, 5000, 65535, 65535, 262143, 0);
      run_ticks(150);

      drain();
      set_config(3, 4, 5000, 20, 100, 7, 131071);
      run_ticks(60);

      drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
